// ===== rtl/fltpm_pkg.sv =====
// Shared types and constants of the four-level page table mapper.
package fltpm_pkg;

   // Default store size in table frames
   localparam int TABLE_FRAMES_DEF = 64;

   // Field widths
   localparam int IDX_W      = 9;
   localparam int ENTRY_W    = 64;
   localparam int FRAME_W    = 40;
   localparam int VPAGE_W    = 36;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 80;

   // Level of the last-level table
   localparam logic [1:0] LEAF_LEVEL = 2'd3;

   // Entry layout
   localparam logic [ENTRY_W-1:0] FLAG_PRESENT     = 64'h0000_0000_0000_0001;
   localparam logic [ENTRY_W-1:0] FLAG_WRITABLE    = 64'h0000_0000_0000_0002;
   localparam logic [ENTRY_W-1:0] FRAME_FIELD_MASK = 64'h000F_FFFF_FFFF_F000;

   // Result status codes
   localparam logic STATUS_MAPPED  = 1'b0;
   localparam logic STATUS_NO_ROOM = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic mem_rd;
      logic red_start;
      logic walk_adv;
      logic alloc_begin;
      logic alloc_adv;
      logic leaf_wr;
      logic load_rsp;
   } fltpm_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic present;
      logic red_done;
      logic at_leaf;
      logic no_room;
   } fltpm_status_type;

endpackage

// ===== rtl/fltpm_rem.sv =====
// Remainder unit: reduces a 40-bit frame offset modulo the table frame count.
module fltpm_rem
   import fltpm_pkg::*;
#(
   parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [FRAME_W-1:0]              value,
   output logic                            done,
   output logic [$clog2(TABLE_FRAMES)-1:0] rem
);

   localparam int  TW   = $clog2(TABLE_FRAMES);
   localparam bit  POW2 = (TABLE_FRAMES & (TABLE_FRAMES - 1)) == 0;

   generate
      if (POW2) begin : g_mask
         logic          done_ff;
         logic [TW-1:0] rem_ff;

         // Take the low bits into a register
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               rem_ff <= value[TW-1:0];
            end
         end

         assign done = done_ff;
         assign rem  = rem_ff;
      end else begin : g_serial
         localparam int ACC_W = TW + 8;
         localparam int STEPS = FRAME_W / 8;

         logic               busy_ff;
         logic               done_ff;
         logic [2:0]         step_ff;
         logic [TW-1:0]      rem_ff;
         logic [FRAME_W-1:0] val_ff;
         logic [ACC_W-1:0]   acc;

         // Fold in one byte and reduce by conditional subtraction
         always_comb begin
            acc = {rem_ff, val_ff[FRAME_W-1 -: 8]};
            for (int k = 7; k >= 0; k--) begin
               if (acc >= (ACC_W'(TABLE_FRAMES) << k)) begin
                  acc = acc - (ACC_W'(TABLE_FRAMES) << k);
               end
            end
         end

         // Step one byte per cycle, most significant first
         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
               step_ff <= '0;
            end else begin
               done_ff <= 1'b0;
               if (start) begin
                  busy_ff <= 1'b1;
                  step_ff <= '0;
               end else if (busy_ff) begin
                  step_ff <= step_ff + 3'd1;
                  if (step_ff == 3'(STEPS - 1)) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
            if (start) begin
               rem_ff <= '0;
               val_ff <= value;
            end else if (busy_ff) begin
               rem_ff <= acc[TW-1:0];
               val_ff <= val_ff << 8;
            end
         end

         assign done = done_ff;
         assign rem  = rem_ff;
      end
   endgenerate

endmodule

// ===== rtl/fltpm_datapath.sv =====
// Datapath: table store, walk registers, allocator, base register and result word.
module fltpm_datapath
   import fltpm_pkg::*;
#(
   parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fltpm_cmd_type         cmd,
   output fltpm_status_type      status,
   input  logic [REQ_DATA_W-1:0] req_data,
   input  logic                  csr_wr,
   input  logic [FRAME_W-1:0]    csr_data,
   output logic [RSP_DATA_W-1:0] rsp_data
);

   localparam int TW    = $clog2(TABLE_FRAMES);
   localparam int AW    = TW + IDX_W;
   localparam int DEPTH = TABLE_FRAMES * (2 ** IDX_W);
   localparam int NFW   = $clog2(TABLE_FRAMES + 1);

   // Table store
   logic [ENTRY_W-1:0]    mem [DEPTH];
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [AW-1:0]         mem_addr;
   logic                  mem_we;
   logic [ENTRY_W-1:0]    mem_wdata;

   // Walk and allocator state
   logic [AW-1:0]         clr_ff;
   logic [FRAME_W-1:0]    base_ff;
   logic [NFW-1:0]        nf_ff;
   logic [VPAGE_W-1:0]    vp_ff;
   logic [FRAME_W-1:0]    pf_ff;
   logic [1:0]            lv_ff;
   logic [TW-1:0]         t_ff;
   logic [1:0]            need_ff;
   logic                  err_ff;
   logic [ENTRY_W-1:0]    leaf_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [IDX_W-1:0]      idx_sel;
   logic [FRAME_W-1:0]    new_frame;
   logic [ENTRY_W-1:0]    entry_new;
   logic [FRAME_W-1:0]    diff;
   logic [1:0]            need_cur;
   logic [NFW:0]          need_sum;
   logic                  red_done;
   logic [TW-1:0]         red_rem;

   // Pick the index of the current level, root first
   always_comb begin
      case (lv_ff)
         2'd0:    idx_sel = vp_ff[35:27];
         2'd1:    idx_sel = vp_ff[26:18];
         2'd2:    idx_sel = vp_ff[17:9];
         default: idx_sel = vp_ff[8:0];
      endcase
   end

   // Build the entry to write: keep other bits, set frame, present, writable
   assign new_frame = cmd.leaf_wr ? pf_ff : base_ff + FRAME_W'(nf_ff);
   assign entry_new = (rd_data_ff & ~(FRAME_FIELD_MASK | FLAG_PRESENT | FLAG_WRITABLE))
                    | {12'd0, new_frame, 12'd0} | FLAG_PRESENT | FLAG_WRITABLE;

   // Memory port: clear sweep or walk address
   assign mem_addr  = cmd.clear_step ? clr_ff : {t_ff, idx_sel};
   assign mem_we    = cmd.clear_step | cmd.alloc_adv | cmd.leaf_wr;
   assign mem_wdata = cmd.clear_step ? '0 : entry_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   // Offset of the entry's frame from the base, reduced to a table index
   assign diff = rd_data_ff[51:12] - base_ff;

   fltpm_rem #(
      .TABLE_FRAMES (TABLE_FRAMES)
   ) u_rem (
      .clock (clock),
      .reset (reset),
      .start (cmd.red_start),
      .value (diff),
      .done  (red_done),
      .rem   (red_rem)
   );

   // Room check for the missing levels
   assign need_cur = LEAF_LEVEL - lv_ff;
   assign need_sum = {1'b0, nf_ff} + (NFW + 1)'(need_cur);

   assign status.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign status.present    = rd_data_ff[0];
   assign status.red_done   = red_done;
   assign status.at_leaf    = (lv_ff == LEAF_LEVEL);
   assign status.no_room    = (need_sum > (NFW + 1)'(TABLE_FRAMES));

   // Control registers: clear counter, base, allocator
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         base_ff <= '0;
         nf_ff   <= NFW'(1);
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (csr_wr) begin
            base_ff <= csr_data;
         end
         if (cmd.alloc_adv) begin
            nf_ff <= nf_ff + NFW'(1);
         end
      end
   end

   // Walk registers and result word
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         vp_ff <= req_data[VPAGE_W-1:0];
         pf_ff <= req_data[VPAGE_W +: FRAME_W];
         lv_ff <= 2'd0;
         t_ff  <= '0;
      end else if (cmd.walk_adv) begin
         lv_ff <= lv_ff + 2'd1;
         t_ff  <= red_rem;
      end else if (cmd.alloc_adv) begin
         lv_ff <= lv_ff + 2'd1;
         t_ff  <= nf_ff[TW-1:0];
      end
      if (cmd.alloc_begin) begin
         need_ff <= need_cur;
         err_ff  <= status.no_room;
      end
      if (cmd.leaf_wr) begin
         leaf_ff <= entry_new;
      end
      if (cmd.load_rsp) begin
         if (err_ff) begin
            rsp_data_ff <= {7'd0, 64'd0, 6'd0, 2'd0, STATUS_NO_ROOM};
         end else begin
            rsp_data_ff <= {7'd0, leaf_ff, 6'(t_ff), need_ff, STATUS_MAPPED};
         end
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== rtl/fltpm_ctrl.sv =====
// Controller: sequences clearing, the table walk, allocation and the result word.
module fltpm_ctrl
   import fltpm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  fltpm_status_type status,
   output fltpm_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_WALK_RED,
      ST_CHECK,
      ST_ALLOC_RD,
      ST_ALLOC_WR,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            if (status.at_leaf) begin
               state_in = ST_CHECK;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            if (status.present) begin
               cmd.red_start = 1'b1;
               state_in      = ST_WALK_RED;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_WALK_RED: begin
            if (status.red_done) begin
               cmd.walk_adv = 1'b1;
               state_in     = ST_WALK_RD;
            end
         end
         ST_CHECK: begin
            cmd.alloc_begin = 1'b1;
            state_in = status.no_room ? ST_RESULT : ST_ALLOC_RD;
         end
         ST_ALLOC_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_ALLOC_WR;
         end
         ST_ALLOC_WR: begin
            if (status.at_leaf) begin
               cmd.leaf_wr = 1'b1;
               state_in    = ST_RESULT;
            end else begin
               cmd.alloc_adv = 1'b1;
               state_in      = ST_ALLOC_RD;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result word valid until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/four_level_page_table_mapper_unit.sv =====
// Sequence: each present level is read, checked and reduced to a table index (remainder); the
//   first missing level is read and checked (only the leaf test when all three are present),
//   then the room check, a read and a write per table added and for the leaf, and the result
//   word load; a refused mapping skips from the check to the result word. A TABLE_FRAMES that
//   is not a power of two reduces byte by byte. Throughput: one item in flight; the next word
//   is taken once idle after the result is loaded, even while it waits. Reset clears the store.
module four_level_page_table_mapper_unit
   import fltpm_pkg::*;
#(
   parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // virtual_page[35:0], physical_frame[75:36], zero[79:76]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // status[0], tables_added[2:1], leaf_table[8:3], leaf_entry[72:9], zero[79:73]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // table_base_frame
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [FRAME_W-1:0]    csr_data
);

   fltpm_cmd_type    cmd;
   fltpm_status_type status;

   assign csr_ready = 1'b1;

   fltpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fltpm_datapath #(
      .TABLE_FRAMES (TABLE_FRAMES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_tdata),
      .csr_wr   (csr_valid),
      .csr_data (csr_data),
      .rsp_data (rsp_tdata)
   );

endmodule

// ===== rtl/fltpm_checker.sv =====
// Port checker for the page table mapper, bound to the top level.
module fltpm_checker
   import fltpm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Leave reset with no result and no input taken (clearing pass runs)
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("result or ready right after reset");

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Drop all fields of a failed mapping
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] == STATUS_NO_ROOM |-> rsp_tdata[72:1] == '0)
      else $error("no-room result carries data");

   // Mark a written leaf present and writable
   a_leaf_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] == STATUS_MAPPED |-> rsp_tdata[9] && rsp_tdata[10])
      else $error("leaf entry lacks present or writable");

   // Keep padding bits zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[79:73] == '0)
      else $error("result padding not zero");

endmodule

bind four_level_page_table_mapper_unit fltpm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/fltpm_mapping_checker.sv =====
// Checker for the page table mapper: mirrors the table store, predicts and compares results.
module fltpm_mapping_checker
   import fltpm_pkg::*;
#(
   parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // virtual_page[35:0], physical_frame[75:36], zero[79:76]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[0], tables_added[2:1], leaf_table[8:3], leaf_entry[72:9], zero[79:73]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [FRAME_W-1:0]    csr_data,
   output int                    mismatch_count,
   output int                    pending_maps
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES_PER_TABLE = 512;
   localparam int SHOWN_MISMATCHES  = 10;

   typedef struct packed {
      logic               status;
      logic [1:0]         tables_added;
      logic [5:0]         leaf_table;
      logic [ENTRY_W-1:0] leaf_entry;
   } map_result_type;

   logic [ENTRY_W-1:0] table_mem [TABLE_FRAMES*ENTRIES_PER_TABLE];
   logic [FRAME_W-1:0] base_frame;
   int unsigned        alloc_next;
   map_result_type     awaited_results [$];
   map_result_type     got, want;

   // Locate one entry of one table frame
   function automatic int unsigned slot_of(input int unsigned tbl, input logic [IDX_W-1:0] idx);
      return (tbl % TABLE_FRAMES) * ENTRIES_PER_TABLE + idx;
   endfunction

   // Replace the frame field and set present and writable, keep the other bits
   function automatic logic [ENTRY_W-1:0] with_frame(input logic [ENTRY_W-1:0] old,
                                                      input logic [FRAME_W-1:0] frame);
      return (old & ~(FRAME_FIELD_MASK | FLAG_PRESENT | FLAG_WRITABLE))
           | ({24'b0, frame} << 12) | FLAG_PRESENT | FLAG_WRITABLE;
   endfunction

   // Walk, allocate and write the leaf for one mapping request
   function automatic map_result_type map_page(input logic [VPAGE_W-1:0] vp,
                                               input logic [FRAME_W-1:0] pf);
      logic [IDX_W-1:0]   idx [4];
      logic [ENTRY_W-1:0] e, leaf;
      logic [FRAME_W-1:0] diff;
      int unsigned        tbl, found, need, lv, s, fresh;
      map_result_type     r;
      for (lv = 0; lv < 4; lv++)
         idx[lv] = vp[IDX_W*(3-lv) +: IDX_W];
      tbl   = 0;
      found = 0;
      // follow present entries down to the first missing level
      while (found < 3) begin
         e = table_mem[slot_of(tbl, idx[found])];
         if (!e[0])
            break;
         diff  = e[51:12] - base_frame;
         tbl   = int'(diff % TABLE_FRAMES);
         found = found + 1;
      end
      need = 3 - found;
      r    = '0;
      if (alloc_next + need > TABLE_FRAMES) begin
         r.status = STATUS_NO_ROOM;
         return r;
      end
      // hang fresh tables below the last present level
      for (lv = found; lv < 3; lv++) begin
         s            = slot_of(tbl, idx[lv]);
         fresh        = alloc_next;
         alloc_next   = alloc_next + 1;
         table_mem[s] = with_frame(table_mem[s], base_frame + FRAME_W'(fresh));
         tbl          = fresh;
      end
      s              = slot_of(tbl, idx[3]);
      leaf           = with_frame(table_mem[s], pf);
      table_mem[s]   = leaf;
      r.status       = STATUS_MAPPED;
      r.tables_added = need[1:0];
      r.leaf_table   = tbl[5:0];
      r.leaf_entry   = leaf;
      return r;
   endfunction

   // Track register writes, predict on accepted requests, compare on accepted results
   always @(posedge clock) begin
      if (reset) begin
         foreach (table_mem[i])
            table_mem[i] = '0;
         alloc_next     = 1;
         base_frame     = '0;
         mismatch_count = 0;
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready)
            base_frame = csr_data;
         if (req_tvalid && req_tready)
            awaited_results.push_back(map_page(req_tdata[35:0], req_tdata[75:36]));
         if (rsp_tvalid && rsp_tready) begin
            got.status       = rsp_tdata[0];
            got.tables_added = rsp_tdata[2:1];
            got.leaf_table   = rsp_tdata[8:3];
            got.leaf_entry   = rsp_tdata[72:9];
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_MISMATCHES)
                  $display("%0t: result word with no request pending: %h", $realtime, rsp_tdata);
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status || got.tables_added !== want.tables_added ||
                   got.leaf_table !== want.leaf_table || got.leaf_entry !== want.leaf_entry) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOWN_MISMATCHES)
                     $display("%0t: mapping mismatch: expected st=%0d add=%0d tbl=%0d ent=%h, got st=%0d add=%0d tbl=%0d ent=%h",
                              $realtime, want.status, want.tables_added, want.leaf_table,
                              want.leaf_entry, got.status, got.tables_added, got.leaf_table,
                              got.leaf_entry);
               end
            end
         end
      end
      pending_maps = awaited_results.size();
   end

endmodule

// ===== tb/four_level_page_table_mapper_unit_tb.sv =====
// Top of the mapper testbench: clock, reset, request and register stimulus, and the verdict.
module four_level_page_table_mapper_unit_tb
   import fltpm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS = 335;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // virtual_page[35:0], physical_frame[75:36], zero[79:76]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // status[0], tables_added[2:1], leaf_table[8:3], leaf_entry[72:9], zero[79:73]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [FRAME_W-1:0]    csr_data   = '0;
   int                    mismatch_count;
   int                    pending_maps;
   bit                    calm       = 1'b0;
   logic [VPAGE_W-1:0]    mapped_pages [$];

   four_level_page_table_mapper_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   fltpm_mapping_checker mapping_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_maps   (pending_maps)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side at random, except during the calm stretch
   always @(negedge clock) begin
      rsp_tready = calm || ($urandom_range(99) >= 24);
   end

   // Present one mapping word, with random idle cycles ahead of it
   task automatic send_mapping(input logic [VPAGE_W-1:0] vp, input logic [FRAME_W-1:0] pf);
      while (!calm && $urandom_range(99) < 24) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {4'b0, pf, vp};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      mapped_pages.push_back(vp);
   endtask

   // Write the table base register
   task automatic write_base(input logic [FRAME_W-1:0] value);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drop valid and hold until every result word has come back
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_maps != 0)
         @(negedge clock);
   endtask

   initial begin
      logic [FRAME_W-1:0] phase_base [4];
      logic [63:0]        noise;
      logic [VPAGE_W-1:0] known, vp;
      logic [FRAME_W-1:0] pf;
      int unsigned        pick;
      noise         = {$urandom, $urandom};
      phase_base[0] = '1;
      phase_base[1] = noise[39:0];
      phase_base[2] = 40'd1;
      phase_base[3] = 40'd64;

      repeat (9) @(negedge clock);
      reset = 1'b0;
      write_base('0);

      // Directed: field extremes, shared prefixes at each depth, leaf overwrite
      send_mapping(36'h0_0000_0000, 40'h00_0000_0000);
      send_mapping(36'h0_0000_0000, 40'hFF_FFFF_FFFF);
      send_mapping(36'hF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
      send_mapping(36'hF_FFFF_FE00, 40'h12_3456_789A);
      send_mapping(36'hF_FFFC_01FF, 40'h00_0000_0001);
      send_mapping(36'hF_F800_0000, 40'h80_0000_0000);
      send_mapping(36'h5_5555_5555, 40'hAA_AAAA_AAAA);
      send_mapping(36'hA_AAAA_AAAA, 40'h55_5555_5555);
      send_mapping(36'h0_0000_01FF, 40'h00_0000_0001);
      send_mapping(36'h0_0000_0200, 40'h7F_FFFF_FFFF);
      send_mapping(36'h0_0000_0000, 40'h00_0000_0000);
      drain();

      // Random phases, each under its own base frame
      for (int phase = 0; phase < 4; phase++) begin
         write_base(phase_base[phase]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            calm  = (phase == 1 && n < 150);
            noise = {$urandom, $urandom};
            pick  = $urandom_range(99);
            // mostly reuse known paths so the walk goes deep
            if (mapped_pages.size() == 0 || pick >= 94) begin
               vp = noise[35:0];
            end else begin
               known = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
               if (pick < 50)
                  vp = {known[35:9], noise[8:0]};
               else if (pick < 68)
                  vp = known;
               else if (pick < 84)
                  vp = {known[35:18], noise[17:0]};
               else
                  vp = {known[35:27], noise[26:0]};
            end
            pick = $urandom_range(9);
            if (pick == 0)
               pf = '0;
            else if (pick == 1)
               pf = '1;
            else
               pf = noise[63:24];
            send_mapping(vp, pf);
         end
         calm = 1'b0;
         drain();
      end

      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_maps == 0)
         $display("four_level_page_table_mapper_unit_tb: clean");
      else
         $display("four_level_page_table_mapper_unit_tb: errors");
      $finish;
   end

   // Give up after a generous fixed time
   initial begin
      #10_000_000;
      $display("four_level_page_table_mapper_unit_tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fltpm_pkg.sv
rtl/fltpm_rem.sv
rtl/fltpm_datapath.sv
rtl/fltpm_ctrl.sv
rtl/four_level_page_table_mapper_unit.sv
rtl/fltpm_checker.sv
tb/fltpm_mapping_checker.sv
tb/four_level_page_table_mapper_unit_tb.sv
